// ===== sv/pf_pkg.sv =====
`default_nettype none

package pf_pkg;

    localparam int SIDE    = 5;
    localparam int CELLS   = 25;
    localparam int LETTERS = 26;

    localparam logic [4:0] Q_INDEX = 5'd16;
    localparam logic [4:0] X_INDEX = 5'd23;

    localparam logic [7:0] ASCII_LOWER_A = 8'd97;
    localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
    localparam logic [6:0] ASCII_UPPER_A = 7'd65;
    localparam logic [6:0] ASCII_UPPER_Z = 7'd90;

    localparam logic [2:0] CMD_CLEAR    = 3'd0;
    localparam logic [2:0] CMD_KEY_CHAR = 3'd1;
    localparam logic [2:0] CMD_KEY_DONE = 3'd2;
    localparam logic [2:0] CMD_TEXT     = 3'd3;
    localparam logic [2:0] CMD_END      = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_Q        = 2'd1;
    localparam logic [1:0] ST_NO_KEY   = 2'd2;

    typedef logic [5:0] pos_t;

endpackage

`default_nettype wire

// ===== sv/playfair_encipher.sv =====
`default_nettype none

// Channel   Direction  tdata                  tuser          tlast
// s_axis    in         char_code[7:0]         cmd[2:0]       -
// m_axis    out        cipher_char[6:0], 0    status[1:0]    last_of_pair
//
// Key done walks the letters a..z, one letter per cycle through the single
// position-store write port; other commands are handled in the idle state.
// For a pair, each letter position and each cipher letter is one read of a store
// with a single read port, in turn; output stalls hold the cipher letters.
// rst_n clears the control state, placed bits, fill count and pending letter.
// Input is held off while a result waits in the output register.

module playfair_encipher
    import pf_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // char_code[7:0]
    input  wire logic [2:0] s_axis_tuser,   // cmd[2:0]
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // cipher_char[6:0], zero[7]
    output logic            m_axis_tlast,
    output logic [1:0]      m_axis_tuser    // status[1:0]
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_PA   = 3'd2;
    localparam logic [2:0] S_PB   = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_K0   = 3'd5;
    localparam logic [2:0] S_E1   = 3'd6;
    localparam logic [2:0] S_E2   = 3'd7;

    function automatic logic [2:0] inc5(input logic [2:0] v);
        return (v == 3'(SIDE - 1)) ? 3'd0 : v + 3'd1;
    endfunction

    function automatic logic [4:0] cell_of(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

    logic [2:0]         state_reg, state_next;
    logic [LETTERS-1:0] placed_reg, placed_next;
    logic [4:0]         fill_count_reg, fill_count_next;
    logic [2:0]         fill_row_reg, fill_row_next;
    logic [2:0]         fill_col_reg, fill_col_next;
    logic [4:0]         fi_reg, fi_next;
    logic [4:0]         pending_reg, pending_next;
    logic               pending_valid_reg, pending_valid_next;
    logic               key_ready_reg, key_ready_next;
    logic [4:0]         a_reg, a_next;
    logic [4:0]         b_reg, b_next;
    pos_t               pa_reg, pa_next;
    logic [4:0]         cell0_reg, cell0_next;
    logic [4:0]         cell1_reg, cell1_next;
    logic               out_valid_reg, out_valid_next;
    logic [6:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic [1:0]         out_status_reg, out_status_next;

    pos_t               lp_mem [LETTERS];
    pos_t               lp_q_reg;
    logic [4:0]         ks_mem [CELLS];
    logic [4:0]         ks_q_reg;

    logic               lp_we;
    logic [4:0]         lp_waddr;
    logic [4:0]         lp_raddr;
    pos_t               lp_wdata;
    logic               ks_we;
    logic [4:0]         ks_wdata;
    logic [4:0]         ks_raddr;

    logic               in_accept;
    logic               out_free;
    logic               lower;
    logic [4:0]         idx;
    logic [7:0]         idx_wide;
    logic               room;
    logic [2:0]         ra, ca, rb, cb;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign lower     = (s_axis_tdata >= ASCII_LOWER_A) && (s_axis_tdata <= ASCII_LOWER_Z);
    assign idx_wide  = s_axis_tdata - ASCII_LOWER_A;
    assign idx       = lower ? idx_wide[4:0] : 5'd0;
    assign room      = fill_count_reg < 5'(CELLS);
    assign ra        = pa_reg[5:3];
    assign ca        = pa_reg[2:0];
    assign rb        = lp_q_reg[5:3];
    assign cb        = lp_q_reg[2:0];

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_status_reg;

    always_comb
    begin
        state_next         = state_reg;
        placed_next        = placed_reg;
        fill_count_next    = fill_count_reg;
        fill_row_next      = fill_row_reg;
        fill_col_next      = fill_col_reg;
        fi_next            = fi_reg;
        pending_next       = pending_reg;
        pending_valid_next = pending_valid_reg;
        key_ready_next     = key_ready_reg;
        a_next             = a_reg;
        b_next             = b_reg;
        pa_next            = pa_reg;
        cell0_next         = cell0_reg;
        cell1_next         = cell1_reg;
        out_valid_next     = out_valid_reg && !m_axis_tready;
        out_char_next      = out_char_reg;
        out_last_next      = out_last_reg;
        out_status_next    = out_status_reg;
        lp_we              = 1'b0;
        lp_waddr           = idx;
        lp_wdata           = {fill_row_reg, fill_col_reg};
        lp_raddr           = b_reg;
        ks_we              = 1'b0;
        ks_wdata           = idx;
        ks_raddr           = cell0_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    case (s_axis_tuser)
                        CMD_CLEAR:
                        begin
                            placed_next        = '0;
                            fill_count_next    = 5'd0;
                            fill_row_next      = 3'd0;
                            fill_col_next      = 3'd0;
                            pending_next       = 5'd0;
                            pending_valid_next = 1'b0;
                            key_ready_next     = 1'b0;
                        end
                        CMD_KEY_CHAR:
                        begin
                            if (lower && idx == Q_INDEX)
                            begin
                                out_valid_next  = 1'b1;
                                out_char_next   = 7'd0;
                                out_last_next   = 1'b0;
                                out_status_next = ST_Q;
                            end
                            else if (lower && !key_ready_reg && !placed_reg[idx] && room)
                            begin
                                lp_we              = 1'b1;
                                ks_we              = 1'b1;
                                placed_next[idx]   = 1'b1;
                                fill_count_next    = fill_count_reg + 5'd1;
                                fill_col_next      = inc5(fill_col_reg);
                                if (fill_col_reg == 3'(SIDE - 1))
                                begin
                                    fill_row_next = fill_row_reg + 3'd1;
                                end
                            end
                        end
                        CMD_KEY_DONE:
                        begin
                            if (!key_ready_reg)
                            begin
                                fi_next    = 5'd0;
                                state_next = S_FILL;
                            end
                        end
                        CMD_TEXT:
                        begin
                            if (lower)
                            begin
                                if (!key_ready_reg)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_char_next   = 7'd0;
                                    out_last_next   = 1'b0;
                                    out_status_next = ST_NO_KEY;
                                end
                                else if (idx == Q_INDEX)
                                begin
                                    out_valid_next  = 1'b1;
                                    out_char_next   = 7'd0;
                                    out_last_next   = 1'b0;
                                    out_status_next = ST_Q;
                                end
                                else if (!pending_valid_reg)
                                begin
                                    pending_next       = idx;
                                    pending_valid_next = 1'b1;
                                end
                                else if (pending_reg == idx)
                                begin
                                    a_next     = pending_reg;
                                    b_next     = X_INDEX;
                                    state_next = S_PA;
                                end
                                else
                                begin
                                    a_next             = pending_reg;
                                    b_next             = idx;
                                    pending_valid_next = 1'b0;
                                    state_next         = S_PA;
                                end
                            end
                        end
                        CMD_END:
                        begin
                            if (pending_valid_reg && key_ready_reg)
                            begin
                                a_next             = pending_reg;
                                b_next             = X_INDEX;
                                pending_valid_next = 1'b0;
                                state_next         = S_PA;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                lp_waddr = fi_reg;
                ks_wdata = fi_reg;
                if (fi_reg != Q_INDEX && !placed_reg[fi_reg] && room)
                begin
                    lp_we               = 1'b1;
                    ks_we               = 1'b1;
                    placed_next[fi_reg] = 1'b1;
                    fill_count_next     = fill_count_reg + 5'd1;
                    fill_col_next       = inc5(fill_col_reg);
                    if (fill_col_reg == 3'(SIDE - 1))
                    begin
                        fill_row_next = fill_row_reg + 3'd1;
                    end
                end
                if (fi_reg == 5'(LETTERS - 1))
                begin
                    key_ready_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    fi_next = fi_reg + 5'd1;
                end
            end
            S_PA:
            begin
                lp_raddr   = a_reg;
                state_next = S_PB;
            end
            S_PB:
            begin
                pa_next    = lp_q_reg;
                state_next = S_CALC;
            end
            S_CALC:
            begin
                if (ra == rb)
                begin
                    cell0_next = cell_of(ra, inc5(ca));
                    cell1_next = cell_of(rb, inc5(cb));
                end
                else if (ca == cb)
                begin
                    cell0_next = cell_of(inc5(ra), ca);
                    cell1_next = cell_of(inc5(rb), cb);
                end
                else
                begin
                    cell0_next = cell_of(ra, cb);
                    cell1_next = cell_of(rb, ca);
                end
                state_next = S_K0;
            end
            S_K0:
            begin
                ks_raddr   = cell0_reg;
                state_next = S_E1;
            end
            S_E1:
            begin
                ks_raddr = out_free ? cell1_reg : cell0_reg;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = {2'b00, ks_q_reg} + ASCII_UPPER_A;
                    out_last_next   = 1'b0;
                    out_status_next = ST_OK;
                    state_next      = S_E2;
                end
            end
            S_E2:
            begin
                ks_raddr = cell1_reg;
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_char_next   = {2'b00, ks_q_reg} + ASCII_UPPER_A;
                    out_last_next   = 1'b1;
                    out_status_next = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (lp_we)
        begin
            lp_mem[lp_waddr] <= lp_wdata;
        end
        lp_q_reg <= lp_mem[lp_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ks_we)
        begin
            ks_mem[fill_count_reg] <= ks_wdata;
        end
        ks_q_reg <= ks_mem[ks_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            placed_reg        <= '0;
            fill_count_reg    <= 5'd0;
            fill_row_reg      <= 3'd0;
            fill_col_reg      <= 3'd0;
            fi_reg            <= 5'd0;
            pending_reg       <= 5'd0;
            pending_valid_reg <= 1'b0;
            key_ready_reg     <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            placed_reg        <= placed_next;
            fill_count_reg    <= fill_count_next;
            fill_row_reg      <= fill_row_next;
            fill_col_reg      <= fill_col_next;
            fi_reg            <= fi_next;
            pending_reg       <= pending_next;
            pending_valid_reg <= pending_valid_next;
            key_ready_reg     <= key_ready_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        pa_reg         <= pa_next;
        cell0_reg      <= cell0_next;
        cell1_reg      <= cell1_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

endmodule

`default_nettype wire

// ===== sv/pf_checker.sv =====
`default_nettype none

module pf_checker
    import pf_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_axis_tready,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic [1:0] m_axis_tuser
);

    logic out_txn;

    assign out_txn = m_axis_tvalid && m_axis_tready;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    a_flag_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |->
            (m_axis_tdata == 8'd0 && !m_axis_tlast))
        else $error("flag result carries a letter");

    a_letter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |->
            (m_axis_tdata >= {1'b0, ASCII_UPPER_A} && m_axis_tdata <= {1'b0, ASCII_UPPER_Z}))
        else $error("cipher letter out of range");

    a_no_input_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input taken while a result waits");

    a_pair_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_txn && m_axis_tuser == ST_OK && !m_axis_tlast) |=> !s_axis_tready)
        else $error("input taken between the letters of a pair");

endmodule

bind playfair_encipher pf_checker u_pf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
